>>> design/bucket_quota_ledger_defines.svh
// Assertion macros shared by the ledger RTL.
`ifndef BUCKET_QUOTA_LEDGER_DEFINES_SVH
`define BUCKET_QUOTA_LEDGER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BQL_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bql check failed");
// Next-cycle implication checked outside reset.
`define BQL_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bql check failed");
`endif

>>> design/bql_pkg.sv
// Package: operation codes, status codes and payload types of the quota ledger.
`default_nettype none
package bql_pkg;
  localparam int unsigned CntW = 48;
  typedef enum logic [3:0] {
    OP_SEED = 4'd0, OP_TRACK = 4'd1, OP_FORGET = 4'd2, OP_SET_QUOTA = 4'd3,
    OP_ADMIT = 4'd4, OP_EXTEND = 4'd5, OP_GIVE_BACK = 4'd6, OP_REC_OBJECT = 4'd7,
    OP_REC_PART = 4'd8, OP_DELETE = 4'd9, OP_ABORTED = 4'd10, OP_COMPLETED = 4'd11,
    OP_QUERY = 4'd12, OP_TOTALS = 4'd13, OP_SPARE14 = 4'd14, OP_SPARE15 = 4'd15
  } op_e;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_BELOW_USAGE = 2'd1, ST_NO_CAPACITY = 2'd2, ST_EXCEEDED = 2'd3
  } status_e;
  typedef struct packed {
    logic [3:0]      mode;
    logic [5:0]      bucket_index;
    logic [CntW-1:0] quota_bytes;
    logic [CntW-1:0] held_bytes;
    logic [CntW-1:0] request_bytes;
    logic [CntW-1:0] stored_bytes;
    logic [CntW-1:0] replaced_bytes;
    logic [CntW-1:0] released_bytes;
    logic [CntW-1:0] seed_used;
    logic [CntW-1:0] seed_pending;
  } req_t;
  typedef struct packed {
    logic [1:0]      status;
    logic            entry_present;
    logic [CntW-1:0] quota_out;
    logic [CntW-1:0] used_out;
    logic [CntW-1:0] pending_out;
    logic [CntW-1:0] reserved_out;
    logic [CntW-1:0] reservation_bytes;
    logic [CntW-1:0] remaining_bytes;
    logic [CntW-1:0] allocated_total;
    logic [CntW-1:0] used_total;
    logic [6:0]      unlimited_count;
  } rsp_t;
endpackage
`default_nettype wire

>>> design/bql_req_if.sv
// Interface: request channel of the quota ledger.
`default_nettype none
interface bql_req_if;
  logic valid;
  logic ready;
  bql_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/bql_rsp_if.sv
// Interface: response channel of the quota ledger.
`default_nettype none
interface bql_rsp_if;
  logic valid;
  logic ready;
  bql_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/bql_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bql_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

>>> design/bucket_quota_ledger.sv
// Top level: per-bucket byte quota ledger with a shared sequencer.
// Each request transaction is taken only while the sequencer is idle. A
// per-bucket operation reads the bucket row from the RAM, registers it,
// computes, writes back and presents the result. Set quota, admit and
// instance totals first sweep every bucket row through shared saturating
// adders, one row a cycle, over the single RAM port. A response waits in
// the output register until taken; the next request is taken only after
// that. Entries carry valid bits in flip-flops, cleared at reset, so no
// clearing pass is run; an invalid entry reads as all zero. Counts
// saturate at the package count width.
`default_nettype none
`include "bucket_quota_ledger_defines.svh"
module bucket_quota_ledger #(
  parameter int unsigned NUM_BUCKETS = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [bql_pkg::CntW-1:0] cfg_wdata_i,
  bql_req_if.sink                     req,
  bql_rsp_if.source                   rsp
);
  localparam int unsigned AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned W = bql_pkg::CntW;
  localparam int unsigned RW = 4 * W;
  localparam int unsigned OW = bql_pkg::CntW;
  localparam logic [W-1:0] CMax = {W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_SWEEP, S_READ, S_LOAD, S_EXEC, S_RESP
  } state_e;

  typedef struct packed {
    logic [W-1:0] quota;
    logic [W-1:0] used;
    logic [W-1:0] pend;
    logic [W-1:0] resv;
  } row_t;

  state_e state_q;
  bql_pkg::req_t req_q;
  logic [OW-1:0] alloc_cap_q;
  logic [NUM_BUCKETS-1:0] valid_q;
  logic [AW:0] sw_cnt_q;
  logic [AW-1:0] sw_idx_q;
  logic sw_live_q;
  logic [W-1:0] qsum_q, usum_q;
  logic [6:0] unl_q;
  row_t row_q;
  logic row_valid_q;
  logic rsp_valid_q;
  bql_pkg::rsp_t rsp_q;

  // Clamp a 48-bit field to the count width.
  function automatic logic [W-1:0] clampv(input logic [OW-1:0] x);
    logic [63:0] xe;
    xe = 64'(x);
    clampv = (xe > 64'(CMax)) ? CMax : W'(xe);
  endfunction
  function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sadd = s[W] ? CMax : s[W-1:0];
  endfunction
  function automatic logic [W-1:0] take(input logic [W-1:0] a, input logic [W-1:0] b);
    take = (a > b) ? a - b : '0;
  endfunction
  function automatic logic exceeds(input logic [W-1:0] a, input logic [W-1:0] b,
                                   input logic [W-1:0] lim);
    exceeds = (b > lim) || (a > lim - b);
  endfunction

  // RAM port: the sweep or the addressed bucket.
  logic ram_we;
  logic [AW-1:0] ram_addr;
  row_t ram_wdata, ram_rdata;
  bql_ram #(.Width(RW), .Depth(NUM_BUCKETS)) u_rows (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  logic [5:0] bidx;
  logic ok_idx;
  logic [AW-1:0] baddr;
  assign bidx = req_q.bucket_index;
  assign ok_idx = 32'(bidx) < NUM_BUCKETS;
  assign baddr = AW'(bidx);
  assign ram_addr = (state_q == S_SWEEP) ? sw_idx_q : baddr;

  // Execute: compute the new row and response from the registered row.
  row_t cur, nrow;
  logic nvalid, wr_en;
  bql_pkg::status_e st;
  logic [W-1:0] quota, held, reqb, stored, repl, rel, resv, charge, wanted, remain;
  bql_pkg::op_e op;
  always_comb begin
    op = bql_pkg::op_e'(req_q.mode);
    quota = clampv(req_q.quota_bytes);
    held = clampv(req_q.held_bytes);
    reqb = clampv(req_q.request_bytes);
    stored = clampv(req_q.stored_bytes);
    repl = clampv(req_q.replaced_bytes);
    rel = clampv(req_q.released_bytes);
    cur = row_valid_q ? row_q : '0;
    nrow = cur;
    nvalid = row_valid_q;
    st = bql_pkg::ST_OK;
    resv = '0;
    wanted = reqb - held;
    charge = sadd(sadd(cur.used, cur.pend), cur.resv);
    if (op == bql_pkg::OP_ADMIT) begin
      if (alloc_cap_q != '0 && quota != '0 && exceeds(qsum_q, quota, clampv(alloc_cap_q)))
        st = bql_pkg::ST_NO_CAPACITY;
    end else if (op != bql_pkg::OP_TOTALS && ok_idx) begin
      unique case (op)
        bql_pkg::OP_SEED: begin
          nvalid = 1'b1;
          nrow = '{quota: quota, used: clampv(req_q.seed_used),
                   pend: clampv(req_q.seed_pending), resv: '0};
        end
        bql_pkg::OP_TRACK: begin
          nvalid = 1'b1;
          nrow.quota = quota;
        end
        bql_pkg::OP_FORGET: begin
          nvalid = 1'b0;
          nrow = '0;
        end
        bql_pkg::OP_SET_QUOTA: begin
          nvalid = 1'b1;
          if (quota != '0 && quota < charge) st = bql_pkg::ST_BELOW_USAGE;
          else if (alloc_cap_q != '0 && quota != '0 &&
                   exceeds(qsum_q, quota, clampv(alloc_cap_q)))
            st = bql_pkg::ST_NO_CAPACITY;
          else nrow.quota = quota;
        end
        bql_pkg::OP_EXTEND: begin
          resv = held;
          if (reqb > held) begin
            nvalid = 1'b1;
            if (cur.quota != '0 && exceeds(charge, wanted, cur.quota))
              st = bql_pkg::ST_EXCEEDED;
            else begin
              nrow.resv = sadd(cur.resv, wanted);
              resv = reqb;
            end
          end
        end
        bql_pkg::OP_GIVE_BACK: begin
          if (reqb != '0 && row_valid_q) nrow.resv = take(cur.resv, reqb);
        end
        bql_pkg::OP_REC_OBJECT, bql_pkg::OP_REC_PART: begin
          nvalid = 1'b1;
          if (held != '0) nrow.resv = take(cur.resv, held);
          if (op == bql_pkg::OP_REC_OBJECT) nrow.used = take(sadd(cur.used, stored), repl);
          else nrow.pend = take(sadd(cur.pend, stored), repl);
        end
        bql_pkg::OP_DELETE: begin
          if (rel != '0) begin
            nvalid = 1'b1;
            nrow.used = take(cur.used, rel);
          end
        end
        bql_pkg::OP_ABORTED: begin
          if (rel != '0) begin
            nvalid = 1'b1;
            nrow.pend = take(cur.pend, rel);
          end
        end
        bql_pkg::OP_COMPLETED: begin
          nvalid = 1'b1;
          nrow.pend = take(cur.pend, rel);
          nrow.used = take(sadd(cur.used, stored), repl);
        end
        default: begin
        end
      endcase
    end
    wr_en = ok_idx && (op != bql_pkg::OP_ADMIT) && (op != bql_pkg::OP_TOTALS);
    remain = (nvalid && nrow.quota != '0) ?
             take(nrow.quota, sadd(sadd(nrow.used, nrow.pend), nrow.resv)) : '0;
  end

  assign ram_we = (state_q == S_EXEC) && wr_en;
  assign ram_wdata = nrow;
  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  logic sweep_op;
  assign sweep_op = (req.payload.mode == bql_pkg::OP_SET_QUOTA) ||
                    (req.payload.mode == bql_pkg::OP_ADMIT) ||
                    (req.payload.mode == bql_pkg::OP_TOTALS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      alloc_cap_q <= '0;
      valid_q <= '0;
      rsp_valid_q <= 1'b0;
      sw_cnt_q <= '0;
      sw_idx_q <= '0;
      sw_live_q <= 1'b0;
      qsum_q <= '0;
      usum_q <= '0;
      unl_q <= '0;
      row_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) alloc_cap_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            req_q <= req.payload;
            qsum_q <= '0;
            usum_q <= '0;
            unl_q <= '0;
            sw_cnt_q <= '0;
            sw_idx_q <= '0;
            sw_live_q <= 1'b0;
            state_q <= sweep_op ? S_SWEEP : S_READ;
          end
        end
        S_SWEEP: begin
          // Accumulate the row read last cycle; advance the address.
          if (sw_live_q && valid_q[AW'(sw_cnt_q - 1'b1)]) begin
            // Leave the addressed bucket out of the quota sum for set quota.
            if (!(req_q.mode == bql_pkg::OP_SET_QUOTA && ok_idx &&
                  AW'(sw_cnt_q - 1'b1) == baddr))
              qsum_q <= sadd(qsum_q, ram_rdata.quota);
            usum_q <= sadd(usum_q, ram_rdata.used);
            if (ram_rdata.quota == '0) unl_q <= unl_q + 7'd1;
          end
          sw_live_q <= 32'(sw_cnt_q) < NUM_BUCKETS;
          if (32'(sw_cnt_q) == NUM_BUCKETS) state_q <= S_READ;
          else begin
            sw_cnt_q <= sw_cnt_q + 1'b1;
            sw_idx_q <= (32'(sw_cnt_q) + 1 < NUM_BUCKETS) ? sw_idx_q + 1'b1 : sw_idx_q;
          end
        end
        S_READ: state_q <= S_LOAD;
        S_LOAD: begin
          row_q <= ram_rdata;
          row_valid_q <= ok_idx && valid_q[baddr];
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (wr_en) valid_q[baddr] <= nvalid;
          rsp_q.status <= st;
          rsp_q.entry_present <= ok_idx && nvalid;
          rsp_q.quota_out <= (ok_idx && nvalid) ? OW'(nrow.quota) : '0;
          rsp_q.used_out <= (ok_idx && nvalid) ? OW'(nrow.used) : '0;
          rsp_q.pending_out <= (ok_idx && nvalid) ? OW'(nrow.pend) : '0;
          rsp_q.reserved_out <= (ok_idx && nvalid) ? OW'(nrow.resv) : '0;
          rsp_q.reservation_bytes <= OW'(resv);
          if (op == bql_pkg::OP_TOTALS) begin
            rsp_q.remaining_bytes <= OW'(take(clampv(alloc_cap_q), qsum_q));
            rsp_q.allocated_total <= OW'(qsum_q);
            rsp_q.used_total <= OW'(usum_q);
            rsp_q.unlimited_count <= unl_q;
          end else begin
            rsp_q.remaining_bytes <= ok_idx ? OW'(remain) : '0;
            rsp_q.allocated_total <= '0;
            rsp_q.used_total <= '0;
            rsp_q.unlimited_count <= '0;
          end
          rsp_valid_q <= 1'b1;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp.ready) begin
            rsp_valid_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BQL_ASSERT_IMP(a_valid_only_resp, clk_i, rst_ni, rsp_valid_q, state_q == S_RESP)
  `BQL_ASSERT_IMP(a_no_ready_busy, clk_i, rst_ni, state_q != S_IDLE, !req.ready)
  `BQL_ASSERT_NXT(a_exec_to_resp, clk_i, rst_ni, state_q == S_EXEC, rsp_valid_q)
  `BQL_ASSERT_IMP(a_unl_bound, clk_i, rst_ni, 1'b1, 32'(unl_q) <= NUM_BUCKETS)
endmodule
`default_nettype wire
